>>> rtl/nrg_pkg.sv
// ----------------------------------------------------------------------------
// nrg_pkg
// Shared types, codes and name helpers for the name registry with aging.
// ----------------------------------------------------------------------------
`default_nettype none

package nrg_pkg;

   // table geometry and reset value of the hold time
   localparam int         NRG_ENTRIES   = 256;
   localparam logic [7:0] HOLD_RESET    = 8'd15;
   localparam int         NAME_BYTES    = 16;

   // request function codes
   localparam logic [1:0] FUNC_ANNOUNCE = 2'd0;
   localparam logic [1:0] FUNC_QUERY    = 2'd1;
   localparam logic [1:0] FUNC_TICK     = 2'd2;

   // entry levels
   localparam logic [1:0] LEVEL_EMPTY    = 2'd0;
   localparam logic [1:0] LEVEL_DOUBTFUL = 2'd1;
   localparam logic [1:0] LEVEL_USED     = 2'd2;

   // query status codes
   localparam logic STATUS_FOUND     = 1'b0;
   localparam logic STATUS_NOT_FOUND = 1'b1;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] ip_addr;
      logic [15:0] port;
      logic [63:0] name_lo;
      logic [63:0] name_hi;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [31:0] found_addr;
      logic [15:0] found_port;
   } rsp_type;

   // one table entry as held in the memory
   typedef struct packed {
      logic [1:0]  level;
      logic [7:0]  countdown;
      logic [31:0] addr;
      logic [15:0] port;
      logic [63:0] name_lo;
      logic [63:0] name_hi;
   } entry_type;

   // per-entry evaluation handed from the evaluator to the controller
   typedef struct packed {
      logic       live;
      logic       addr_hit;
      logic       name_hit;
      logic [1:0] aged_level;
      logic [7:0] aged_count;
   } eval_type;

   // clear every byte after the first zero byte, and always the last byte
   function automatic logic [127:0] normalize_name(input logic [127:0] name);
      logic [127:0] res;
      logic         keep;
      res  = '0;
      keep = 1'b1;
      for (int i = 0; i < NAME_BYTES - 1; i++) begin
         keep = keep & (name[8*i +: 8] != 8'd0);
         if (keep) begin
            res[8*i +: 8] = name[8*i +: 8];
         end
      end
      return res;
   endfunction

   // byte-wise compare that ends at the first zero byte
   function automatic logic names_match(input logic [127:0] stored,
                                        input logic [127:0] query);
      logic eq_run;
      logic hit;
      eq_run = 1'b1;
      hit    = 1'b0;
      for (int i = 0; i < NAME_BYTES; i++) begin
         eq_run = eq_run & (stored[8*i +: 8] == query[8*i +: 8]);
         if (eq_run && (stored[8*i +: 8] == 8'd0)) begin
            hit = 1'b1;
         end
      end
      return hit | eq_run;
   endfunction

endpackage

`default_nettype wire

>>> rtl/nrg_ram.sv
// ----------------------------------------------------------------------------
// nrg_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module nrg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/nrg_eval.sv
// ----------------------------------------------------------------------------
// nrg_eval
// Evaluates one entry read from the table against the current transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module nrg_eval
   import nrg_pkg::*;
(
   input  wire entry_type  entry,
   input  wire req_type    req,
   input  wire logic [7:0] hold_time,
   output eval_type        ev
);

   logic expired;

   assign expired = (entry.countdown == 8'd0);

   // liveness and the two searches
   always_comb begin
      ev.live     = (entry.level != LEVEL_EMPTY);
      ev.addr_hit = ev.live && (entry.addr == req.ip_addr);
      ev.name_hit = ev.live && names_match({entry.name_hi, entry.name_lo},
                                           {req.name_hi, req.name_lo});
      // aging step: drop one level and reload, or count down
      ev.aged_level = expired ? (entry.level - 2'd1) : entry.level;
      ev.aged_count = expired ? hold_time : (entry.countdown - 8'd1);
   end

endmodule

`default_nettype wire

>>> rtl/name_registry_with_aging_unit.sv
// A query result turns valid once the scan has read every table entry and the
// result register is free; req_ready stays low until an announce, query or
// tick is done, and does not drop at all for an unused function code.
// Only one transaction is in flight: a new one is taken only after the last
// is done, and the scan reads one table entry per cycle.
// Reset: synchronous; a clearing pass empties the table with req_ready low,
// and the hold time returns to 15 seconds.
// ----------------------------------------------------------------------------
// name_registry_with_aging_unit
// Name table with aging: announce, query and one-second tick, scanned
// through one entry RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module name_registry_with_aging_unit
   import nrg_pkg::*;
#(
   parameter int ENTRIES = NRG_ENTRIES
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data,
   input  wire logic       csr_wr_en,
   input  wire logic [7:0] csr_wr_data
);

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int EW = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_RESP
   } state_type;

   // registers and their next values
   state_type   state_ff, state_in;
   logic [CW-1:0] iss_ff, iss_in;
   logic        dv_ff, dv_in;
   logic [IW-1:0] dix_ff, dix_in;
   req_type     req_ff, req_in;
   logic [7:0]  hold_ff, hold_in;
   logic        hit_ff, hit_in;
   logic [IW-1:0] hit_slot_ff, hit_slot_in;
   logic [15:0] hit_port_ff, hit_port_in;
   logic        emp_ff, emp_in;
   logic [IW-1:0] emp_slot_ff, emp_slot_in;
   logic        fnd_ff, fnd_in;
   logic [31:0] fnd_addr_ff, fnd_addr_in;
   logic [15:0] fnd_port_ff, fnd_port_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   // memory ports
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic [EW-1:0] rd_word;
   entry_type     rd_entry;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   entry_type     wr_entry;
   eval_type      ev;
   logic          last;
   logic [127:0]  norm_name;

   assign rd_en    = (state_ff == ST_SCAN) && (iss_ff < CW'(ENTRIES));
   assign rd_addr  = iss_ff[IW-1:0];
   assign rd_entry = entry_type'(rd_word);
   assign last     = dv_ff && (dix_ff == IW'(ENTRIES - 1));
   assign norm_name = normalize_name({req_ff.name_hi, req_ff.name_lo});

   nrg_ram #(
      .WIDTH (EW),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (EW'(wr_entry)),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   nrg_eval u_eval (
      .entry     (rd_entry),
      .req       (req_ff),
      .hold_time (hold_ff),
      .ev        (ev)
   );

   // next-state and datapath control
   always_comb begin
      state_in     = state_ff;
      iss_in       = iss_ff;
      dv_in        = 1'b0;
      dix_in       = dix_ff;
      req_in       = req_ff;
      hold_in      = csr_wr_en ? csr_wr_data : hold_ff;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      hit_port_in  = hit_port_ff;
      emp_in       = emp_ff;
      emp_slot_in  = emp_slot_ff;
      fnd_in       = fnd_ff;
      fnd_addr_in  = fnd_addr_ff;
      fnd_port_in  = fnd_port_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = dix_ff;
      wr_entry     = rd_entry;

      case (state_ff)
         // empty the table one entry per cycle
         ST_CLEAR: begin
            wr_en    = 1'b1;
            wr_addr  = iss_ff[IW-1:0];
            wr_entry = '0;
            iss_in   = iss_ff + CW'(1);
            if (iss_ff[IW-1:0] == IW'(ENTRIES - 1)) begin
               iss_in   = '0;
               state_in = ST_IDLE;
            end
         end

         // take a new transaction
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               iss_in = '0;
               hit_in = 1'b0;
               emp_in = 1'b0;
               fnd_in = 1'b0;
               if (req_data.func inside {FUNC_ANNOUNCE, FUNC_QUERY, FUNC_TICK}) begin
                  state_in = ST_SCAN;
               end
            end
         end

         // walk all entries, one read issued and one evaluated per cycle
         ST_SCAN: begin
            dv_in  = rd_en;
            dix_in = rd_addr;
            if (rd_en) begin
               iss_in = iss_ff + CW'(1);
            end
            if (dv_ff) begin
               case (req_ff.func)
                  FUNC_TICK: begin
                     if (ev.live) begin
                        wr_en              = 1'b1;
                        wr_entry.level     = ev.aged_level;
                        wr_entry.countdown = ev.aged_count;
                     end
                  end
                  FUNC_ANNOUNCE: begin
                     if (ev.addr_hit && !hit_ff) begin
                        hit_in      = 1'b1;
                        hit_slot_in = dix_ff;
                        hit_port_in = rd_entry.port;
                     end
                     if (!ev.live && !emp_ff) begin
                        emp_in      = 1'b1;
                        emp_slot_in = dix_ff;
                     end
                  end
                  FUNC_QUERY: begin
                     if (ev.name_hit && !fnd_ff) begin
                        fnd_in      = 1'b1;
                        fnd_addr_in = rd_entry.addr;
                        fnd_port_in = rd_entry.port;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            if (last) begin
               case (req_ff.func)
                  FUNC_ANNOUNCE: state_in = ST_WRITE;
                  FUNC_QUERY:    state_in = ST_RESP;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end

         // refresh the matching entry or claim the first empty one
         ST_WRITE: begin
            wr_en              = hit_ff || emp_ff;
            wr_addr            = hit_ff ? hit_slot_ff : emp_slot_ff;
            wr_entry.level     = LEVEL_USED;
            wr_entry.countdown = hold_ff;
            wr_entry.addr      = req_ff.ip_addr;
            wr_entry.port      = hit_ff ? hit_port_ff : req_ff.port;
            wr_entry.name_hi   = norm_name[127:64];
            wr_entry.name_lo   = norm_name[63:0];
            state_in           = ST_IDLE;
         end

         // hand the query result to the output register once it is free
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_in.status     = fnd_ff ? STATUS_FOUND : STATUS_NOT_FOUND;
               rsp_in.found_addr = fnd_ff ? fnd_addr_ff : 32'd0;
               rsp_in.found_port = fnd_ff ? fnd_port_ff : 16'd0;
               state_in          = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         iss_ff       <= '0;
         dv_ff        <= 1'b0;
         hold_ff      <= HOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iss_ff       <= iss_in;
         dv_ff        <= dv_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dix_ff      <= dix_in;
      req_ff      <= req_in;
      hit_ff      <= hit_in;
      hit_slot_ff <= hit_slot_in;
      hit_port_ff <= hit_port_in;
      emp_ff      <= emp_in;
      emp_slot_ff <= emp_slot_in;
      fnd_ff      <= fnd_in;
      fnd_addr_ff <= fnd_addr_in;
      fnd_port_ff <= fnd_port_in;
      rsp_ff      <= rsp_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

>>> rtl/nrg_checker.sv
// ----------------------------------------------------------------------------
// nrg_checker
// Port-level checks for the name registry, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nrg_checker
   import nrg_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // a miss carries zero address and port
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_NOT_FOUND)
         |-> (rsp_data.found_addr == 32'd0) && (rsp_data.found_port == 16'd0))
      else $error("not-found result with nonzero address or port");

   // the clearing pass keeps the request side closed right after reset
   a_clear_pass: assert property (@(posedge clock)
      $past(reset) |-> !req_ready)
      else $error("request taken during clearing pass");

   // a scanning transaction closes the request side
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
         (req_data.func == FUNC_ANNOUNCE || req_data.func == FUNC_QUERY ||
          req_data.func == FUNC_TICK) |=> !req_ready)
      else $error("new transaction taken during a scan");

   // a result never appears right after a transaction is taken
   a_rsp_delay: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result too early");

endmodule

bind name_registry_with_aging_unit nrg_checker u_nrg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
